### src/i64da_pkg.sv
package i64da_pkg;

    localparam int VALUE_W             = 64;
    localparam int CHAR_W              = 8;
    localparam int NUM_DIGITS          = 19;
    localparam int BCD_W               = 4 * NUM_DIGITS;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2d;

    // Classified number: sign and unsigned magnitude
    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } item_t;

endpackage

### src/i64da_front.sv
module i64da_front
    import i64da_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [VALUE_W-1:0] in_value,
    output logic               q_valid,
    input  logic               q_ready,
    output item_t              q_item
);

    logic  valid_reg, valid_next;
    item_t item_reg, item_next;
    logic  take;

    assign in_ready = !valid_reg || q_ready;
    assign take     = in_valid && in_ready;
    assign q_valid  = valid_reg;
    assign q_item   = item_reg;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (q_ready) begin
            valid_next = 1'b0;
        end
        if (take) begin
            valid_next    = 1'b1;
            item_next.neg = in_value[VALUE_W-1];
            // unsigned magnitude covers the most negative value as well
            item_next.mag = in_value[VALUE_W-1] ? (~in_value + VALUE_W'(1)) : in_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

endmodule

### src/i64da_queue.sv
module i64da_queue
    import i64da_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  wr_valid,
    output logic  wr_ready,
    input  item_t wr_item,
    output logic  rd_valid,
    input  logic  rd_ready,
    output item_t rd_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push, pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
        if (push) begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

### src/i64da_back.sv
module i64da_back
    import i64da_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  item_t             q_item,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CHAR_W-1:0] out_char,
    output logic              out_last
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_DIGITS
    } state_t;

    localparam int CNT_W = $clog2(VALUE_W);
    localparam int DIG_W = $clog2(NUM_DIGITS + 1);

    state_t             state_reg, state_next;
    logic [VALUE_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DIG_W-1:0]   dig_reg, dig_next;
    logic               neg_reg, neg_next;
    logic               valid_reg, valid_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic               last_reg, last_next;

    logic [BCD_W-1:0]   bcd_adj;
    logic [3:0]         top_digit;
    logic               can_load;

    assign q_ready   = (state_reg == ST_IDLE);
    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;
    assign can_load  = !valid_reg || out_ready;
    assign top_digit = bcd_reg[BCD_W-1 -: 4];

    // add three to every digit of five or more before the shift
    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            bcd_adj[4*d +: 4] = (bcd_reg[4*d +: 4] >= 4'd5) ?
                                (bcd_reg[4*d +: 4] + 4'd3) : bcd_reg[4*d +: 4];
        end
    end

    always_comb begin
        state_next = state_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        dig_next   = dig_reg;
        neg_next   = neg_reg;
        valid_next = valid_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        if (out_ready) begin
            valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    bin_next   = q_item.mag;
                    neg_next   = q_item.neg;
                    bcd_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                {bcd_next, bin_next} = {bcd_adj, bin_reg} << 1;
                cnt_next             = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(VALUE_W - 1)) begin
                    dig_next   = DIG_W'(NUM_DIGITS);
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (top_digit == 4'd0 && dig_reg != DIG_W'(1)) begin
                    bcd_next = bcd_reg << 4;
                    dig_next = dig_reg - DIG_W'(1);
                end else begin
                    state_next = neg_reg ? ST_SIGN : ST_DIGITS;
                end
            end
            ST_SIGN: begin
                if (can_load) begin
                    valid_next = 1'b1;
                    char_next  = ASCII_MINUS;
                    last_next  = 1'b0;
                    state_next = ST_DIGITS;
                end
            end
            ST_DIGITS: begin
                if (can_load) begin
                    valid_next = 1'b1;
                    char_next  = ASCII_ZERO + CHAR_W'(top_digit);
                    last_next  = (dig_reg == DIG_W'(1));
                    bcd_next   = bcd_reg << 4;
                    dig_next   = dig_reg - DIG_W'(1);
                    if (dig_reg == DIG_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        cnt_reg  <= cnt_next;
        dig_reg  <= dig_next;
        neg_reg  <= neg_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

endmodule

### src/int64_to_decimal_ascii_top.sv
// Signed 64-bit integer to decimal ASCII, one character per output beat, most significant first.
// Path from input beat to first character: front register, queue, load, 64-step bit-serial
// binary-to-BCD loop, leading-zero skip.
// While a number is loaded, converted, stripped of leading zeros and emitted sign first, the
// queue holds the next.
// Reset: aresetn is synchronous, active low; clears valid flags, queue pointers and the sequencer.
module int64_to_decimal_ascii_top
    import i64da_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    // input beat
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [VALUE_W-1:0] s_tdata,   // [63:0] value (signed)
    // output beat
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [CHAR_W-1:0]  m_tdata,   // [7:0] character
    output logic               m_tlast    // last character of the number
);

    item_t f_item, q_item;
    logic  f_valid, f_ready;
    logic  q_valid, q_ready;

    // Front: register the beat, split sign from unsigned magnitude
    i64da_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_value (s_tdata),
        .q_valid  (f_valid),
        .q_ready  (f_ready),
        .q_item   (f_item)
    );

    // Queue: hold classified numbers while the back end is busy converting
    i64da_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_item  (f_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_item  (q_item)
    );

    // Back: double-dabble conversion, drop leading zeros, emit the sign when negative, then digits
    i64da_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

### src/i64da_checker.sv
module i64da_checker
    import i64da_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic [VALUE_W-1:0] s_tdata,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [CHAR_W-1:0]  m_tdata,
    input logic               m_tlast
);

    // a stalled input beat holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("input beat changed while stalled");

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    a_char_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata == ASCII_MINUS) ||
                     ((m_tdata >= ASCII_ZERO) && (m_tdata <= ASCII_ZERO + 8'd9)))
        else $error("character outside sign and digits");

    a_minus_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata == ASCII_MINUS) |-> !m_tlast)
        else $error("minus sign flagged as last");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind int64_to_decimal_ascii_top i64da_checker u_i64da_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
